### src/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// shared types and constants for the pair set table
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int unsigned FIELD_WIDTH = 16;
    localparam int unsigned COUNT_WIDTH = 5;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic add_en;
        logic remove_en;
        logic clear_en;
    } cell_ctrl_t;

endpackage

### src/pst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_req_if
// request channel: kind of request and the pair it names
// ----------------------------------------------------------------------------
interface pst_req_if;
    logic                                    valid;
    logic                                    ready;
    pst_pkg::req_kind_t                      req_type;
    logic [pst_pkg::FIELD_WIDTH-1:0]         first_value;
    logic [pst_pkg::FIELD_WIDTH-1:0]         second_value;

    modport source (
        output valid,
        output req_type,
        output first_value,
        output second_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  first_value,
        input  second_value,
        output ready
    );
endinterface

### src/pst_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_rsp_if
// response channel: success flag and pair count after the request
// ----------------------------------------------------------------------------
interface pst_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    success;
    logic [pst_pkg::COUNT_WIDTH-1:0]         pair_count;

    modport source (
        output valid,
        output success,
        output pair_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  success,
        input  pair_count,
        output ready
    );
endinterface

### src/pst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_cell
// one entry of the table: holds a pair, compares it with the key, and takes
// its upper neighbour's entry when a removal at or below it compacts the row
// ----------------------------------------------------------------------------
module pst_cell #(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pst_pkg::cell_ctrl_t      ctrl,
    input  logic [VALUE_WIDTH-1:0]   key_first,
    input  logic [VALUE_WIDTH-1:0]   key_second,
    input  logic                     hit_in,
    output logic                     hit_out,
    input  logic                     prev_valid,
    input  logic                     up_valid,
    input  logic [VALUE_WIDTH-1:0]   up_first,
    input  logic [VALUE_WIDTH-1:0]   up_second,
    output logic                     valid,
    output logic [VALUE_WIDTH-1:0]   first,
    output logic [VALUE_WIDTH-1:0]   second
);
    import pst_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [VALUE_WIDTH-1:0] first_reg;
    logic [VALUE_WIDTH-1:0] first_next;
    logic [VALUE_WIDTH-1:0] second_reg;
    logic [VALUE_WIDTH-1:0] second_next;
    logic                   match;

    assign match   = valid_reg && (first_reg == key_first) && (second_reg == key_second);
    assign hit_out = hit_in | match;

    always_comb
    begin
        valid_next  = valid_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (ctrl.clear_en)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.remove_en && hit_out)
        begin
            valid_next  = up_valid;
            first_next  = up_first;
            second_next = up_second;
        end
        else if (ctrl.add_en && !valid_reg && prev_valid)
        begin
            valid_next  = 1'b1;
            first_next  = key_first;
            second_next = key_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign valid  = valid_reg;
    assign first  = first_reg;
    assign second = second_reg;

endmodule

### src/pair_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_set_table
// set of ordered pairs in insertion order, with lookup, add, remove and clear
// ----------------------------------------------------------------------------
// response valid rises in the cycle after the request transfer; throughput:
// one request per cycle while rsp.ready is high; the row of cells compares
// and shifts in the same cycle, so the response register alone sets the pace
// reset: all entries invalid, count zero, no response pending
// ----------------------------------------------------------------------------
module pair_set_table #(
    parameter int unsigned PAIR_CAPACITY = 16,
    parameter int unsigned VALUE_WIDTH   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pst_req_if.sink    req,
    pst_rsp_if.source  rsp
);
    import pst_pkg::*;

    localparam int unsigned CW = $clog2(PAIR_CAPACITY + 1);

    logic                   req_fire;
    logic [VALUE_WIDTH-1:0] key_first;
    logic [VALUE_WIDTH-1:0] key_second;
    logic [PAIR_CAPACITY:0] hit_chain;
    logic                   hit_any;
    logic                   full;
    logic                   add_ok;
    logic                   success_next;
    cell_ctrl_t             ctrl;

    logic [PAIR_CAPACITY-1:0]                  cell_valid;
    logic [PAIR_CAPACITY-1:0][VALUE_WIDTH-1:0] cell_first;
    logic [PAIR_CAPACITY-1:0][VALUE_WIDTH-1:0] cell_second;

    logic [CW-1:0]          held_count_reg;
    logic [CW-1:0]          held_count_next;
    logic [CW+4:0]          count_ext;
    logic                   rsp_valid_reg;
    logic                   success_reg;
    logic [COUNT_WIDTH-1:0] pair_count_reg;

    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign req_fire   = req.valid && req.ready;
    assign key_first  = VALUE_WIDTH'(req.first_value);
    assign key_second = VALUE_WIDTH'(req.second_value);

    assign hit_chain[0] = 1'b0;
    assign hit_any      = hit_chain[PAIR_CAPACITY];
    assign full         = cell_valid[PAIR_CAPACITY-1];
    assign add_ok       = !hit_any && !full;

    always_comb
    begin
        ctrl            = '0;
        success_next    = 1'b0;
        held_count_next = held_count_reg;
        unique case (req.req_type)
            REQ_LOOKUP:
            begin
                success_next = hit_any;
            end
            REQ_ADD:
            begin
                ctrl.add_en  = req_fire && add_ok;
                success_next = add_ok;
                if (add_ok)
                begin
                    held_count_next = held_count_reg + CW'(1);
                end
            end
            REQ_REMOVE:
            begin
                ctrl.remove_en = req_fire && hit_any;
                success_next   = hit_any;
                if (hit_any)
                begin
                    held_count_next = held_count_reg - CW'(1);
                end
            end
            REQ_CLEAR:
            begin
                ctrl.clear_en   = req_fire;
                success_next    = 1'b1;
                held_count_next = '0;
            end
            default:
            begin
                success_next = 1'b0;
            end
        endcase
    end

    generate
        for (genvar i = 0; i < PAIR_CAPACITY; i++)
        begin : g_cell
            logic                   prev_valid;
            logic                   up_valid;
            logic [VALUE_WIDTH-1:0] up_first;
            logic [VALUE_WIDTH-1:0] up_second;

            if (i == 0)
            begin : g_bottom
                assign prev_valid = 1'b1;
            end
            else
            begin : g_mid_lo
                assign prev_valid = cell_valid[i-1];
            end

            if (i == PAIR_CAPACITY - 1)
            begin : g_top
                assign up_valid  = 1'b0;
                assign up_first  = '0;
                assign up_second = '0;
            end
            else
            begin : g_mid_hi
                assign up_valid  = cell_valid[i+1];
                assign up_first  = cell_first[i+1];
                assign up_second = cell_second[i+1];
            end

            pst_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key_first  (key_first),
                .key_second (key_second),
                .hit_in     (hit_chain[i]),
                .hit_out    (hit_chain[i+1]),
                .prev_valid (prev_valid),
                .up_valid   (up_valid),
                .up_first   (up_first),
                .up_second  (up_second),
                .valid      (cell_valid[i]),
                .first      (cell_first[i]),
                .second     (cell_second[i])
            );
        end
    endgenerate

    assign count_ext = (CW+5)'(held_count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                held_count_reg <= held_count_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            success_reg    <= success_next;
            pair_count_reg <= count_ext[COUNT_WIDTH-1:0];
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.success    = success_reg;
    assign rsp.pair_count = pair_count_reg;

endmodule

### verif/pair_set_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_set_table_tb
// Self-checking bench for the pair set table. A driver feeds lookup, add,
// remove and clear requests from a queue and a monitor compares every
// response with a shadow copy of the set kept in the bench. Both channels
// idle in random bursts, except towards the end of the run.
// ----------------------------------------------------------------------------
module pair_set_table_tb;

    import pst_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int POOL_SIZE      = 24;
    localparam int TAIL_ITEMS     = 60;
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTED   = 10;

    typedef struct {
        req_kind_t              kind;
        logic [FIELD_WIDTH-1:0] first;
        logic [FIELD_WIDTH-1:0] second;
    } pair_req_t;

    typedef struct {
        logic                   success;
        logic [COUNT_WIDTH-1:0] pair_count;
    } table_result_t;

    logic clk;
    logic rst_n;

    pst_req_if req_ch ();
    pst_rsp_if rsp_ch ();

    pair_set_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pair_req_t              pending_reqs[$];
    table_result_t          awaited_results[$];
    pair_req_t              next_req;

    logic [FIELD_WIDTH-1:0] held_first[TABLE_DEPTH];
    logic [FIELD_WIDTH-1:0] held_second[TABLE_DEPTH];
    int                     held_n;

    logic [FIELD_WIDTH-1:0] pool_first[POOL_SIZE];
    logic [FIELD_WIDTH-1:0] pool_second[POOL_SIZE];

    logic req_took;
    int   send_gap;
    int   drain_gap;
    int   idle_odds;
    int   transfer_tally;
    int   quiet_cycles;
    int   fault_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // shadow of the set: apply one request, return the response it causes
    function automatic table_result_t apply_request(req_kind_t kind,
                                                    logic [FIELD_WIDTH-1:0] a,
                                                    logic [FIELD_WIDTH-1:0] b);
        table_result_t r;
        int            hit;
        hit = -1;
        for (int i = 0; i < held_n; i++)
        begin
            if (held_first[i] == a && held_second[i] == b)
            begin
                hit = i;
                break;
            end
        end
        r.success = 1'b0;
        case (kind)
            REQ_LOOKUP:
            begin
                r.success = (hit >= 0);
            end
            REQ_ADD:
            begin
                if (hit < 0 && held_n < TABLE_DEPTH)
                begin
                    held_first[held_n]  = a;
                    held_second[held_n] = b;
                    held_n++;
                    r.success = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (hit >= 0)
                begin
                    for (int i = hit; i < held_n - 1; i++)
                    begin
                        held_first[i]  = held_first[i + 1];
                        held_second[i] = held_second[i + 1];
                    end
                    held_n--;
                    r.success = 1'b1;
                end
            end
            default:
            begin
                held_n    = 0;
                r.success = 1'b1;
            end
        endcase
        r.pair_count = COUNT_WIDTH'(held_n);
        return r;
    endfunction

    function automatic bit in_tail();
        return pending_reqs.size() < TAIL_ITEMS;
    endfunction

    task automatic queue_request(req_kind_t kind, logic [FIELD_WIDTH-1:0] a,
                                 logic [FIELD_WIDTH-1:0] b);
        pair_req_t item;
        item.kind   = kind;
        item.first  = a;
        item.second = b;
        pending_reqs.push_back(item);
    endtask

    task automatic note_fault(string what);
        fault_count++;
        if (fault_count <= MAX_REPORTED)
            $display("%0t ns: %s", $time, what);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_took))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                next_req = pending_reqs.pop_front();
                req_ch.req_type     <= next_req.kind;
                req_ch.first_value  <= next_req.first;
                req_ch.second_value <= next_req.second;
                req_ch.valid        <= 1'b1;
                if (idle_odds != 0 && !in_tail() && $urandom_range(1, idle_odds) == 1)
                    send_gap = $urandom_range(1, 17);
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (drain_gap > 0)
            begin
                drain_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (idle_odds != 0 && !in_tail() && $urandom_range(1, idle_odds) == 1)
                    drain_gap = $urandom_range(1, 17);
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            table_result_t want;
            req_took <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_results.push_back(apply_request(req_ch.req_type,
                    req_ch.first_value, req_ch.second_value));
                transfer_tally++;
                if (transfer_tally % 64 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       idle_odds = 0;
                        1:       idle_odds = 3;
                        default: idle_odds = 8;
                    endcase
                end
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    note_fault($sformatf("response with none awaited: success %0b count %0d",
                        rsp_ch.success, rsp_ch.pair_count));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.success !== want.success
                        || rsp_ch.pair_count !== want.pair_count)
                        note_fault($sformatf(
                            "mismatch: success %0b count %0d, expected %0b count %0d",
                            rsp_ch.success, rsp_ch.pair_count,
                            want.success, want.pair_count));
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int add_weight;
        int pick;
        int roll;
        logic [FIELD_WIDTH-1:0] a;
        logic [FIELD_WIDTH-1:0] b;
        req_kind_t kind;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_LOOKUP;
        req_ch.first_value  = '0;
        req_ch.second_value = '0;
        rsp_ch.ready        = 1'b0;
        req_took            = 1'b0;
        send_gap            = 0;
        drain_gap           = 0;
        idle_odds           = 3;
        transfer_tally      = 0;
        quiet_cycles        = 0;
        fault_count         = 0;
        held_n              = 0;

        // directed: empty set, extremes, duplicates, shifting remove
        queue_request(REQ_LOOKUP, 16'h0000, 16'h0000);
        queue_request(REQ_REMOVE, 16'h0000, 16'h0000);
        queue_request(REQ_CLEAR,  16'hFFFF, 16'hFFFF);
        queue_request(REQ_ADD,    16'h0000, 16'h0000);
        queue_request(REQ_ADD,    16'hFFFF, 16'hFFFF);
        queue_request(REQ_ADD,    16'h0000, 16'h0000);
        queue_request(REQ_ADD,    16'hFFFF, 16'h0000);
        queue_request(REQ_ADD,    16'h0000, 16'hFFFF);
        queue_request(REQ_LOOKUP, 16'hFFFF, 16'h0000);
        queue_request(REQ_LOOKUP, 16'h0001, 16'h0001);
        queue_request(REQ_REMOVE, 16'hFFFF, 16'hFFFF);
        queue_request(REQ_LOOKUP, 16'h0000, 16'hFFFF);
        queue_request(REQ_LOOKUP, 16'hFFFF, 16'hFFFF);
        queue_request(REQ_REMOVE, 16'h1234, 16'h5678);
        queue_request(REQ_CLEAR,  16'h0000, 16'h0000);

        // pool of pairs so that hits are common; some share one member
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_first[i]  = FIELD_WIDTH'($urandom);
            pool_second[i] = FIELD_WIDTH'($urandom);
        end
        pool_first[0]  = '0;
        pool_second[0] = '1;
        pool_first[1]  = '1;
        pool_second[1] = '0;
        pool_first[3]  = pool_first[2];
        pool_second[5] = pool_second[4];

        // fill to capacity, then one add too many
        for (int i = 0; i <= TABLE_DEPTH; i++)
            queue_request(REQ_ADD, pool_first[i], pool_second[i]);
        queue_request(REQ_LOOKUP, pool_first[TABLE_DEPTH], pool_second[TABLE_DEPTH]);
        queue_request(REQ_REMOVE, pool_first[0], pool_second[0]);
        queue_request(REQ_LOOKUP, pool_first[15], pool_second[15]);

        add_weight = 45;
        for (int n = 0; n < 465; n++)
        begin
            if (n % 60 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       add_weight = 20;
                    1:       add_weight = 45;
                    default: add_weight = 70;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                kind = REQ_CLEAR;
            else if (roll < 3 + add_weight)
                kind = REQ_ADD;
            else if (roll % 2 == 0)
                kind = REQ_LOOKUP;
            else
                kind = REQ_REMOVE;
            if ($urandom_range(0, 99) < 85)
            begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                a = pool_first[pick];
                b = pool_second[pick];
            end
            else
            begin
                a = FIELD_WIDTH'($urandom);
                b = FIELD_WIDTH'($urandom);
            end
            queue_request(kind, a, b);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && !req_ch.valid);
        wait (awaited_results.size() == 0);
        repeat (8) @(posedge clk);

        if (fault_count == 0 && awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
